// ===== hdl/multipart_frame_deframer_top_assert.svh =====
// assertion macros used by the deframer sequencer module
`ifndef MULTIPART_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define MULTIPART_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfd: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfd: next-cycle check failed");

`endif

// ===== hdl/mfd_pkg.sv =====
// shared constants, types and helpers of the multipart deframer
package mfd_pkg;

  localparam int MAX_BOUNDARY = 70;
  localparam int SIZE_BITS    = 24;
  localparam int KEY_LEN      = 9;
  localparam int BLANK_LEN    = 4;
  localparam int WIN_DEPTH    = (MAX_BOUNDARY + 1 > KEY_LEN) ? MAX_BOUNDARY + 1 : KEY_LEN;
  localparam int LEN_W        = $clog2(MAX_BOUNDARY + 1);
  localparam int CNT_W        = SIZE_BITS;
  localparam int FIELD_W      = 24;
  localparam int EXT_W        = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // "boundary=" in arrival order
  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h62, 8'h6f, 8'h75, 8'h6e, 8'h64, 8'h61, 8'h72, 8'h79, 8'h3d
  };

  // blank line after the part headers, arrival order
  localparam logic [7:0] BLANK_TEXT [BLANK_LEN] = '{CH_CR, CH_LF, CH_CR, CH_LF};

  typedef enum logic [2:0] {
    PH_KEY,
    PH_TOKEN,
    PH_BOUND,
    PH_BLANK,
    PH_DATA,
    PH_HALT
  } phase_t;

  // controls broadcast to every cell of the window chain
  typedef struct packed {
    logic win_shift;
    logic pat_shift;
    logic act_clear;
  } chain_ctrl_t;

  // compare results gathered from the chain
  typedef struct packed {
    logic       key_hit;
    logic       blank_hit;
    logic       bound_hit;
    logic [7:0] tap_byte;
  } chain_stat_t;

  // clip a byte count to the result field
  function automatic logic [FIELD_W-1:0] clip_size(input logic [CNT_W-1:0] val);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(val);
    if (ext > EXT_W'(FIELD_MAX)) begin
      return FIELD_MAX;
    end
    return FIELD_W'(ext);
  endfunction

endpackage

// ===== hdl/mfd_cell.sv =====
// one cell of the window chain: history byte, boundary byte and its active flag
module mfd_cell
  import mfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  chain_ctrl_t ctrl,
  input  logic [7:0]  win_in,
  input  logic [7:0]  pat_in,
  input  logic        act_in,
  output logic [7:0]  win_out,
  output logic [7:0]  pat_out,
  output logic        act_out,
  output logic        hit,
  output logic [7:0]  sel_byte
);

  logic [7:0] win_r;
  logic [7:0] pat_r;
  logic       act_r;
  logic       act_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.win_shift) begin
      win_r <= win_in;
    end
    if (ctrl.pat_shift) begin
      pat_r <= pat_in;
    end
  end

  always_comb begin
    act_nxt = act_r;
    if (ctrl.act_clear) begin
      act_nxt = 1'b0;
    end else if (ctrl.pat_shift) begin
      act_nxt = act_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  assign win_out  = win_r;
  assign pat_out  = pat_r;
  assign act_out  = act_r;
  // compare against the byte that moves in on this shift
  assign hit      = !act_r || (win_in == pat_r);
  // first inactive cell is the delay line tap
  assign sel_byte = (act_in && !act_r) ? win_in : 8'h00;

endmodule

// ===== hdl/mfd_ctrl.sv =====
// phase sequencer, byte counter, pending frame end and result register
module mfd_ctrl
  import mfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_stream_byte,
  input  logic               in_stream_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_out_byte,
  output logic               out_frame_end,
  output logic [FIELD_W-1:0] out_frame_size,
  output logic               out_boundary_error,
  output chain_ctrl_t        chain_ctrl,
  input  chain_stat_t        chain_stat
);

  `include "multipart_frame_deframer_top_assert.svh"

  phase_t             phase_r;
  phase_t             phase_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_new;
  logic [LEN_W-1:0]   len_r;
  logic               pend_r;
  logic [FIELD_W-1:0] pend_size_r;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_frame_end_r;
  logic [FIELD_W-1:0] out_frame_size_r;
  logic               out_boundary_error_r;

  logic               acc;
  logic               key_ok;
  logic               blank_ok;
  logic               bound_ok;
  logic               data_ok;
  logic               len_full;
  logic               push;
  logic               pat_shift;
  logic               len_clear;
  logic               cnt_clear;
  logic               pend_set;
  logic               res_v;
  logic               res_end;
  logic               res_err;
  logic [7:0]         res_byte;
  logic [FIELD_W-1:0] res_size;
  logic [CNT_W-1:0]   frame_cnt;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  // saturating count including the byte pushed now
  assign cnt_new  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
  assign key_ok   = chain_stat.key_hit && (cnt_new >= CNT_W'(KEY_LEN));
  assign blank_ok = chain_stat.blank_hit && (cnt_new >= CNT_W'(BLANK_LEN));
  assign bound_ok = chain_stat.bound_hit && (cnt_new >= CNT_W'(len_r));
  assign data_ok  = cnt_new > CNT_W'(len_r);
  assign len_full = len_r >= LEN_W'(MAX_BOUNDARY);
  assign frame_cnt = (cnt_new == COUNT_MAX) ? COUNT_MAX : cnt_new - CNT_W'(len_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_stream_restart) begin
        phase_nxt = PH_KEY;
      end else begin
        case (phase_r)
          PH_KEY: begin
            if (key_ok) begin
              phase_nxt = PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            if (in_stream_byte != CH_QUOTE) begin
              if (in_stream_byte == CH_CR) begin
                phase_nxt = (len_r == '0) ? PH_HALT : PH_BOUND;
              end else if (len_full) begin
                phase_nxt = PH_HALT;
              end
            end
          end
          PH_BOUND: begin
            if (bound_ok) begin
              phase_nxt = PH_BLANK;
            end
          end
          PH_BLANK: begin
            if (blank_ok) begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            if (bound_ok) begin
              phase_nxt = PH_BLANK;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // per-beat actions and result
  always_comb begin
    push      = 1'b0;
    pat_shift = 1'b0;
    len_clear = 1'b0;
    cnt_clear = 1'b0;
    pend_set  = 1'b0;
    res_v     = 1'b0;
    res_end   = 1'b0;
    res_err   = 1'b0;
    res_byte  = 8'h00;
    res_size  = '0;
    if (acc) begin
      if (pend_r) begin
        res_v    = 1'b1;
        res_end  = 1'b1;
        res_size = pend_size_r;
      end
      if (in_stream_restart) begin
        len_clear = 1'b1;
        cnt_clear = 1'b1;
      end else begin
        case (phase_r)
          PH_KEY: begin
            push = 1'b1;
            if (key_ok) begin
              len_clear = 1'b1;
              cnt_clear = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (in_stream_byte != CH_QUOTE) begin
              if (in_stream_byte == CH_CR) begin
                if (len_r == '0) begin
                  res_v   = 1'b1;
                  res_err = 1'b1;
                end else begin
                  cnt_clear = 1'b1;
                end
              end else if (len_full) begin
                res_v   = 1'b1;
                res_err = 1'b1;
              end else begin
                pat_shift = 1'b1;
              end
            end
          end
          PH_BOUND: begin
            push = 1'b1;
            if (bound_ok) begin
              cnt_clear = 1'b1;
            end
          end
          PH_BLANK: begin
            push = 1'b1;
            if (blank_ok) begin
              cnt_clear = 1'b1;
            end
          end
          PH_DATA: begin
            push = 1'b1;
            if (bound_ok) begin
              cnt_clear = 1'b1;
              if (data_ok) begin
                pend_set = 1'b1;
                res_v    = 1'b1;
                res_byte = chain_stat.tap_byte;
              end
            end else if (data_ok) begin
              res_v    = 1'b1;
              res_byte = chain_stat.tap_byte;
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      cnt_r       <= '0;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (acc) begin
        pend_r <= pend_set;
        if (cnt_clear) begin
          cnt_r <= '0;
        end else if (push) begin
          cnt_r <= cnt_new;
        end
        if (len_clear) begin
          len_r <= '0;
        end else if (pat_shift) begin
          len_r <= len_r + LEN_W'(1);
        end
      end
      if (acc && res_v) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_set) begin
      pend_size_r <= clip_size(frame_cnt);
    end
    if (acc && res_v) begin
      out_byte_r           <= res_byte;
      out_frame_end_r      <= res_end;
      out_frame_size_r     <= res_size;
      out_boundary_error_r <= res_err;
    end
  end

  assign chain_ctrl.win_shift = push;
  assign chain_ctrl.pat_shift = pat_shift;
  assign chain_ctrl.act_clear = len_clear;

  assign out_valid          = out_valid_r;
  assign out_out_byte       = out_byte_r;
  assign out_frame_end      = out_frame_end_r;
  assign out_frame_size     = out_frame_size_r;
  assign out_boundary_error = out_boundary_error_r;

  `MFD_ASSERT_IMPL(a_pend_in_blank, pend_r, phase_r == PH_BLANK)
  `MFD_ASSERT_NEXT(a_pend_once, acc && pend_r, !pend_r)
  `MFD_ASSERT_IMPL(a_len_range, 1'b1, len_r <= LEN_W'(MAX_BOUNDARY))
  `MFD_ASSERT_NEXT(a_halt_sticky, phase_r == PH_HALT && !(acc && in_stream_restart), phase_r == PH_HALT)
  `MFD_ASSERT_NEXT(a_err_halts, acc && res_err, phase_r == PH_HALT)

endmodule

// ===== hdl/multipart_frame_deframer_top.sv =====
// top level of the multipart stream deframer: window cell chain plus sequencer
// The deframer takes one byte of a multipart HTTP response per beat and hands
// out the image bytes of every part, a frame end beat carrying the part's size
// (saturating at 2^24-1), or a single boundary error beat when the boundary
// token is empty or longer than 70 bytes; after an error it drops bytes until
// a beat with in_stream_restart set. Rate: one input beat per clock, sustained,
// as long as results are taken; the result of a beat appears in the output
// register in the cycle after acceptance, and a new beat is taken in the same
// cycle the waiting result is taken. The rate is set by the 71-cell window
// chain, which shifts one byte per cycle while beats are accepted and compares
// every cell against its captured boundary byte in parallel. Image bytes leave
// the chain delayed by the boundary length, so the bytes of a trailing boundary
// are never forwarded. The frame end beat of a part is emitted on the beat after
// the last image byte, whatever that beat carries. Empty parts produce no beats.
module multipart_frame_deframer_top
  import mfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_stream_byte,
  input  logic               in_stream_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_out_byte,
  output logic               out_frame_end,
  output logic [FIELD_W-1:0] out_frame_size,
  output logic               out_boundary_error
);

  chain_ctrl_t          chain_ctrl;
  chain_stat_t          chain_stat;

  // per-cell connections; cell 0 is fed from the input beat
  logic [7:0]           win_in_v  [WIN_DEPTH];
  logic [7:0]           pat_in_v  [WIN_DEPTH];
  logic                 act_in_v  [WIN_DEPTH];
  logic [7:0]           win_q     [WIN_DEPTH];
  logic [7:0]           pat_q     [WIN_DEPTH];
  logic                 act_q     [WIN_DEPTH];
  logic [7:0]           sel_v     [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] hit_v;

  logic                 key_hit;
  logic                 blank_hit;
  logic [7:0]           tap_byte;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      // new byte enters both the history and the boundary capture
      assign win_in_v[i] = in_stream_byte;
      assign pat_in_v[i] = in_stream_byte;
      assign act_in_v[i] = 1'b1;
    end else begin : g_link
      assign win_in_v[i] = win_q[i-1];
      assign pat_in_v[i] = pat_q[i-1];
      assign act_in_v[i] = act_q[i-1];
    end

    mfd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (chain_ctrl),
      .win_in   (win_in_v[i]),
      .pat_in   (pat_in_v[i]),
      .act_in   (act_in_v[i]),
      .win_out  (win_q[i]),
      .pat_out  (pat_q[i]),
      .act_out  (act_q[i]),
      .hit      (hit_v[i]),
      .sel_byte (sel_v[i])
    );
  end

  // keyword and blank-line detectors look at the window after this shift,
  // newest byte in cell 0
  always_comb begin
    key_hit = 1'b1;
    for (int j = 0; j < KEY_LEN; j++) begin
      if (win_in_v[j] != KEY_TEXT[KEY_LEN-1-j]) begin
        key_hit = 1'b0;
      end
    end
  end

  always_comb begin
    blank_hit = 1'b1;
    for (int j = 0; j < BLANK_LEN; j++) begin
      if (win_in_v[j] != BLANK_TEXT[BLANK_LEN-1-j]) begin
        blank_hit = 1'b0;
      end
    end
  end

  // only the first inactive cell drives its byte, so an or is the tap mux
  always_comb begin
    tap_byte = 8'h00;
    for (int j = 0; j < WIN_DEPTH; j++) begin
      tap_byte = tap_byte | sel_v[j];
    end
  end

  // inactive cells count as a hit, so the and covers exactly the boundary
  assign chain_stat.key_hit   = key_hit;
  assign chain_stat.blank_hit = blank_hit;
  assign chain_stat.bound_hit = &hit_v;
  assign chain_stat.tap_byte  = tap_byte;

  mfd_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_stream_byte     (in_stream_byte),
    .in_stream_restart  (in_stream_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_out_byte       (out_out_byte),
    .out_frame_end      (out_frame_end),
    .out_frame_size     (out_frame_size),
    .out_boundary_error (out_boundary_error),
    .chain_ctrl         (chain_ctrl),
    .chain_stat         (chain_stat)
  );

endmodule
